// File: rtl/npc_pkg.sv
// shared types and constants for the nearest palette colour search
package npc_pkg;

  // request kinds
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // field widths
  localparam int unsigned COMP_W = 8;
  localparam int unsigned IDX_W8 = 8;
  localparam int unsigned DIST_W = 18;

  // running best starts above any reachable distance
  localparam logic [DIST_W-1:0] DIST_START = 18'h3FFFF;

  // input item
  typedef struct packed {
    logic              req_type;
    logic [IDX_W8-1:0] entry_index;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } npc_req_t;

  // result item
  typedef struct packed {
    logic [IDX_W8-1:0] best_index;
    logic [DIST_W-1:0] best_distance;
  } npc_resp_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } npc_state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic wr_en;
    logic scan_en;
    logic load_out;
  } npc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic pipe_busy;
    logic out_free;
  } npc_status_t;

endpackage

// File: rtl/nearest_palette_color_core.sv
// top level of the nearest palette colour search
// A palette write gives no result. A lookup scans every palette entry in
// index order, one entry per cycle through a four-stage read, square, sum
// and compare pipeline. The result sits in an output register, so a new
// item may be taken while the last result still waits. After reset the
// palette reads as a greyscale ramp, entry i = (i,i,i), with no clearing
// pass: a valid bit per entry selects the stored value. Only entries 0..255
// are writable; with more entries the rest stay on the ramp, and best_index
// carries the winning index modulo 256.
module nearest_palette_color_core import npc_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  npc_req_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output npc_resp_t out_data_o
);

  npc_cmd_t    cmd;
  npc_status_t status;

  // controller
  npc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  npc_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_data_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/npc_ctrl.sv
// controller state machine for palette writes and lookup scans
module npc_ctrl import npc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        req_type_i,
  output logic        in_ready_o,
  input  npc_status_t status_i,
  output npc_cmd_t    cmd_o
);

  npc_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (req_type_i == REQ_LOOKUP) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the pipeline to empty and the output register to free up
        if (!status_i.pipe_busy && status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/npc_datapath.sv
// palette memory, distance pipeline, running minimum and output register
module npc_datapath import npc_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  npc_cmd_t    cmd_i,
  input  npc_req_t    req_i,
  output npc_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output npc_resp_t   out_data_o
);

  localparam int unsigned IDX_W  = $clog2(PALETTE_ENTRIES);
  localparam int unsigned MEM_N  = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;
  localparam int unsigned MEM_AW = $clog2(MEM_N);
  localparam bit          WR_ALL = (PALETTE_ENTRIES >= 256);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  // absolute difference of two components
  function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // palette storage, valid bits mark entries written since reset
  logic [3*COMP_W-1:0] mem [MEM_N];
  logic [MEM_N-1:0]    valid_q;

  logic [COMP_W-1:0]   qr_q, qg_q, qb_q;
  logic [IDX_W-1:0]    cnt_q;

  logic                wr_ok;
  logic [MEM_AW-1:0]   waddr;
  logic [MEM_AW-1:0]   raddr;
  logic                in_mem;

  // stage 1: read data
  logic                s1_valid_q;
  logic [3*COMP_W-1:0] rd_data_q;
  logic                rd_valid_q;
  logic [COMP_W-1:0]   s1_ramp_q;
  logic [IDX_W-1:0]    s1_idx_q;

  // stage 2: squared differences
  logic                s2_valid_q;
  logic [2*COMP_W-1:0] sq_r_q, sq_g_q, sq_b_q;
  logic [IDX_W-1:0]    s2_idx_q;

  // stage 3: distance
  logic                s3_valid_q;
  logic [DIST_W-1:0]   dist_q;
  logic [IDX_W-1:0]    s3_idx_q;

  // running best
  logic [DIST_W-1:0]   best_dist_q;
  logic [IDX_W-1:0]    best_idx_q;

  logic                out_valid_q;
  npc_resp_t           out_data_q;

  logic [COMP_W-1:0]   ent_r, ent_g, ent_b;
  logic [COMP_W-1:0]   d_r, d_g, d_b;

  assign wr_ok  = WR_ALL || (32'(req_i.entry_index) < PALETTE_ENTRIES);
  assign waddr  = req_i.entry_index[MEM_AW-1:0];
  assign raddr  = cnt_q[MEM_AW-1:0];
  assign in_mem = (32'(cnt_q) < MEM_N);

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem[waddr] <= {req_i.red, req_i.green, req_i.blue};
    end
    if (cmd_i.scan_en) begin
      rd_data_q <= mem[raddr];
    end
  end

  // valid bits, cleared by reset so unwritten entries read as the ramp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.wr_en && wr_ok) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  // query latch and scan address counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= '0;
    end else if (cmd_i.scan_en) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qr_q <= req_i.red;
      qg_q <= req_i.green;
      qb_q <= req_i.blue;
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.scan_en;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // stage 1 side data
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      rd_valid_q <= valid_q[raddr] && in_mem;
      s1_ramp_q  <= COMP_W'(cnt_q);
      s1_idx_q   <= cnt_q;
    end
  end

  // entry colour: stored value or greyscale ramp
  assign ent_r = rd_valid_q ? rd_data_q[3*COMP_W-1:2*COMP_W] : s1_ramp_q;
  assign ent_g = rd_valid_q ? rd_data_q[2*COMP_W-1:COMP_W]   : s1_ramp_q;
  assign ent_b = rd_valid_q ? rd_data_q[COMP_W-1:0]          : s1_ramp_q;

  assign d_r = abs_diff(ent_r, qr_q);
  assign d_g = abs_diff(ent_g, qg_q);
  assign d_b = abs_diff(ent_b, qb_q);

  // stage 2: squares
  always_ff @(posedge clk_i) begin
    sq_r_q   <= (2*COMP_W)'(d_r) * (2*COMP_W)'(d_r);
    sq_g_q   <= (2*COMP_W)'(d_g) * (2*COMP_W)'(d_g);
    sq_b_q   <= (2*COMP_W)'(d_b) * (2*COMP_W)'(d_b);
    s2_idx_q <= s1_idx_q;
  end

  // stage 3: sum of squares
  always_ff @(posedge clk_i) begin
    dist_q   <= DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
    s3_idx_q <= s2_idx_q;
  end

  // running minimum, strict compare keeps the lower index on ties
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      best_dist_q <= DIST_START;
      best_idx_q  <= '0;
    end else if (s3_valid_q && (dist_q < best_dist_q)) begin
      best_dist_q <= dist_q;
      best_idx_q  <= s3_idx_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q.best_index    <= IDX_W8'(best_idx_q);
      out_data_q.best_distance <= best_dist_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // status back to the controller
  assign status_o.last      = (cnt_q == LAST_IDX);
  assign status_o.pipe_busy = s1_valid_q || s2_valid_q || s3_valid_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// File: tb/palette_match_checker.sv
// transfer monitor, nearest colour predictor and result comparison for the palette search
module palette_match_checker import npc_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  npc_req_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  npc_resp_t   out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // predictor copy of the palette, red in the top byte
  logic [23:0] palette_copy [PALETTE_ENTRIES];
  // answers of accepted lookups, oldest first
  npc_resp_t   lookup_answers [$];
  int unsigned failures;

  initial begin
    failures = 0;
  end

  // exact search over the whole palette, lower index kept on a tie
  function automatic npc_resp_t closest_entry(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    npc_resp_t   res;
    logic [17:0] best_d;
    logic [17:0] d;
    int unsigned best_i;
    int          dr;
    int          dg;
    int          db;
    best_d = DIST_START;
    best_i = 0;
    for (int unsigned i = 0; i < PALETTE_ENTRIES; i++) begin
      dr = int'(palette_copy[i][23:16]) - int'(r);
      dg = int'(palette_copy[i][15:8]) - int'(g);
      db = int'(palette_copy[i][7:0]) - int'(b);
      d  = 18'(dr * dr + dg * dg + db * db);
      if (d < best_d) begin
        best_d = d;
        best_i = i;
      end
    end
    res.best_index    = best_i[7:0];
    res.best_distance = best_d;
    return res;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("%s", msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [7:0] ramp_v;
    npc_resp_t  want;
    if (!rst_ni) begin
      // greyscale ramp, index taken modulo 256
      for (int unsigned i = 0; i < PALETTE_ENTRIES; i++) begin
        ramp_v = i[7:0];
        palette_copy[i] = {ramp_v, ramp_v, ramp_v};
      end
      lookup_answers.delete();
      pending_o <= 0;
    end else begin
      // result transfer against the oldest answer
      if (out_valid_i && out_ready_i) begin
        if (lookup_answers.size() == 0) begin
          note_failure($sformatf("unexpected result: index %0d distance %0d",
                                 out_data_i.best_index, out_data_i.best_distance));
        end else begin
          want = lookup_answers.pop_front();
          if (out_data_i.best_index !== want.best_index) begin
            note_failure($sformatf("best_index mismatch: expected %0d actual %0d",
                                   want.best_index, out_data_i.best_index));
          end
          if (out_data_i.best_distance !== want.best_distance) begin
            note_failure($sformatf("best_distance mismatch: expected %0d actual %0d",
                                   want.best_distance, out_data_i.best_distance));
          end
        end
      end
      // request transfer updates the palette or queues an answer
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.req_type == REQ_WRITE) begin
          if (in_data_i.entry_index < PALETTE_ENTRIES) begin
            palette_copy[in_data_i.entry_index] =
              {in_data_i.red, in_data_i.green, in_data_i.blue};
          end
        end else begin
          lookup_answers.push_back(closest_entry(in_data_i.red, in_data_i.green,
                                                 in_data_i.blue));
        end
      end
      pending_o    <= lookup_answers.size();
      fail_count_o <= failures;
    end
  end

endmodule

// File: tb/tb_nearest_palette_color_core.sv
// stimulus and verdict for the nearest palette colour search
module tb_nearest_palette_color_core;
  import npc_pkg::*;

  localparam int unsigned PALETTE_ENTRIES = 256;
  // transfer to result for one lookup, plus margin
  localparam int unsigned LOOKUP_CYCLES   = PALETTE_ENTRIES + 5;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  npc_req_t    in_data   = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  npc_resp_t   out_data;
  int unsigned fail_count;
  int unsigned pending;

  // no idling on either side while set
  bit          quiet     = 1'b0;
  int unsigned items_sent = 0;

  always #1 clk_i = ~clk_i;

  nearest_palette_color_core #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  palette_match_checker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);
  end

  // run limit
  initial begin
    #10000000;
    $display("tb_nearest_palette_color_core: errors");
    $finish;
  end

  // one request, held until its transfer
  task automatic send_item(input npc_req_t item);
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_entry(input logic [7:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
    npc_req_t item;
    item.req_type    = REQ_WRITE;
    item.entry_index = idx;
    item.red         = r;
    item.green       = g;
    item.blue        = b;
    send_item(item);
  endtask

  // entry_index is don't care on a lookup, so it carries random bits
  task automatic lookup(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    npc_req_t    item;
    logic [7:0]  junk;
    junk             = 8'($urandom_range(255));
    item.req_type    = REQ_LOOKUP;
    item.entry_index = junk;
    item.red         = r;
    item.green       = g;
    item.blue        = b;
    send_item(item);
  endtask

  // sender holds off until every answer has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [7:0] pick_comp();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    case ($urandom_range(9))
      0: v = 8'h00;
      1: v = 8'hFF;
      default: ;
    endcase
    return v;
  endfunction

  // small step from a colour component, saturating
  function automatic logic [7:0] nudge(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // bursts of writes followed by lookups aimed at what was written, with noise
  task automatic run_episodes(input int unsigned count);
    int unsigned target;
    int unsigned nw;
    int unsigned nl;
    logic [7:0]  idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    npc_req_t    item;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 15) begin
        // noise: anything at all
        item = {1'b0, $urandom};
        item.req_type = 1'($urandom_range(1));
        send_item(item);
      end else begin
        nw = $urandom_range(6, 1);
        for (int unsigned k = 0; k < nw; k++) begin
          idx = 8'($urandom_range(255));
          r   = pick_comp();
          g   = pick_comp();
          b   = pick_comp();
          write_entry(idx, r, g, b);
          // same colour at a second index sets up a tie
          if ($urandom_range(99) < 30) begin
            write_entry(8'($urandom_range(255)), r, g, b);
          end
        end
        nl = $urandom_range(3, 1);
        for (int unsigned k = 0; k < nl; k++) begin
          case ($urandom_range(3))
            0: lookup(r, g, b);
            1: lookup(nudge(r), nudge(g), nudge(b));
            2: lookup(pick_comp(), pick_comp(), pick_comp());
            default: lookup({8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}},
                            {8{$urandom_range(1) == 1}});
          endcase
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ramp extremes and corners
    lookup(8'h00, 8'h00, 8'h00);
    lookup(8'hFF, 8'hFF, 8'hFF);
    lookup(8'hFF, 8'h00, 8'h00);
    lookup(8'h00, 8'hFF, 8'h00);
    lookup(8'h00, 8'h00, 8'hFF);
    lookup(8'h80, 8'h7F, 8'h7E);
    // white at entry 0 ties with entry 255, first entry wins
    write_entry(8'h00, 8'hFF, 8'hFF, 8'hFF);
    lookup(8'hFF, 8'hFF, 8'hFF);
    // black only at the top index
    write_entry(8'hFF, 8'h00, 8'h00, 8'h00);
    lookup(8'h00, 8'h00, 8'h00);
    // duplicate colour, lower index wins
    write_entry(8'd100, 8'd10, 8'd200, 8'd30);
    write_entry(8'd50, 8'd10, 8'd200, 8'd30);
    lookup(8'd10, 8'd200, 8'd30);
    lookup(8'd11, 8'd199, 8'd31);
    // alternating bit patterns
    write_entry(8'hAA, 8'h55, 8'hAA, 8'h55);
    write_entry(8'h55, 8'hAA, 8'h55, 8'hAA);
    lookup(8'h55, 8'hAA, 8'h55);
    lookup(8'hAA, 8'h55, 8'hAA);
    // overwrite the same entry, later value counts
    write_entry(8'd50, 8'd1, 8'd2, 8'd3);
    lookup(8'd10, 8'd200, 8'd30);
    write_entry(8'h00, 8'h00, 8'h00, 8'h00);
    write_entry(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    lookup(8'hFF, 8'h00, 8'hFF);

    // random on the partly rewritten ramp
    run_episodes(520);
    wait_drained();

    // all black, then white gives the largest distance
    for (int unsigned i = 0; i < 256; i++) begin
      write_entry(i[7:0], 8'h00, 8'h00, 8'h00);
    end
    lookup(8'hFF, 8'hFF, 8'hFF);
    lookup(8'h00, 8'h00, 8'h00);
    lookup(8'hFF, 8'h00, 8'hFF);
    lookup(pick_comp(), pick_comp(), pick_comp());

    // long stretch with no idling
    quiet = 1'b1;
    run_episodes(300);
    quiet = 1'b0;
    wait_drained();

    // fully random palette
    for (int unsigned i = 0; i < 256; i++) begin
      write_entry(i[7:0], pick_comp(), pick_comp(), pick_comp());
    end
    run_episodes(260);

    // drain and let the pipeline settle
    wait_drained();
    repeat (LOOKUP_CYCLES + 10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_nearest_palette_color_core: clean");
    end else begin
      $display("tb_nearest_palette_color_core: errors");
    end
    $finish;
  end

endmodule
